// ----- sv/owt_pkg.sv -----
// Shared types and constants for the overlapped tile walker.
`timescale 1ns / 1ps

package owt_pkg;

  // Number of independent walks and width of every raster coordinate.
  localparam int unsigned BANDS      = 4;
  localparam int unsigned BAND_BITS  = 2;
  localparam int unsigned COORD_BITS = 16;
  localparam int unsigned OVL_BITS   = 12;
  localparam int unsigned SNAP_BITS  = 8;
  localparam int unsigned CFG_BITS   = 16;
  localparam int unsigned SNAP_CNT_BITS = 4;

  // Operation codes carried with each input transaction.
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_NEXT  = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_MAX_TILE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_MAX_TILE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_OVERLAP_PIXELS  = 2'd2;
  localparam logic [1:0] REG_SNAP_FACTOR     = 2'd3;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SNAP_TC,
    S_SNAP_TR,
    S_EDGE,
    S_BLOCK,
    S_SNAP_BC,
    S_SNAP_BR,
    S_FINISH,
    S_EMIT
  } state_t;

endpackage

// ----- sv/overlapped_tile_walker.sv -----
// Per-band raster tile walker with overlap, clamping and optional snapping.
//
// Channel   Direction  Handshake          Payload
// s_*       in         s_tvalid/s_tready  tdata: raster sizes, tuser: opcode and band
// m_*       out        m_tvalid/m_tready  tdata: block and tile geometry, tuser: valid_res
// cfg_*     in         cfg_we             cfg_index selects the register, cfg_data the value
//
// Start, stop and a next refused at its first check pass through the check and emit steps
// before the result register is loaded. Any other next also runs the edge, block and finish
// steps; with a snap factor above one it adds the four size roundings, each running 16 steps
// through one shared remainder unit.
// One item is in flight at a time; the next is accepted once the result is registered.
// rst is synchronous; it clears the sequencer, band flags, config registers and m_tvalid.
// A stalled output holds its result while the next transaction is already accepted; the
// result of that one then waits in the emit step until the output register is free.
`timescale 1ns / 1ps

module overlapped_tile_walker (
  input  logic                          clk,
  input  logic                          rst,
  // Input stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [31:0]                   s_tdata,   // raster_width, raster_height
  input  logic [3:0]                    s_tuser,   // opcode, band
  // Output stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [127:0]                  m_tdata,   // block_columns, block_rows, block_left,
                                                   // block_top, tile_columns, tile_rows,
                                                   // tile_left, tile_top
  output logic                          m_tuser,   // valid_res
  // Configuration writes
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [owt_pkg::CFG_BITS-1:0]  cfg_data
);

  localparam int unsigned CB = owt_pkg::COORD_BITS;

  // Configuration registers
  logic [CB-1:0]                    max_tile_width;
  logic [CB-1:0]                    max_tile_height;
  logic [owt_pkg::OVL_BITS-1:0]     overlap_pixels;
  logic [owt_pkg::SNAP_BITS-1:0]    snap_factor;

  // Per-band state
  logic                             band_active   [owt_pkg::BANDS];
  logic [CB-1:0]                    band_width    [owt_pkg::BANDS];
  logic [CB-1:0]                    band_height   [owt_pkg::BANDS];
  logic [CB-1:0]                    cursor_column [owt_pkg::BANDS];
  logic [CB-1:0]                    cursor_row    [owt_pkg::BANDS];

  // Captured transaction
  logic [1:0]                       opcode;
  logic [owt_pkg::BAND_BITS-1:0]    band;
  logic [CB-1:0]                    raster_width;
  logic [CB-1:0]                    raster_height;

  // Working registers
  owt_pkg::state_t                  state, state_next;
  logic [CB-1:0]                    cur_w, cur_h, cur_col, cur_row;
  logic [CB-1:0]                    tcols, trows, tright, tbottom;
  logic [CB-1:0]                    bleft, btop, bcols, brows;
  logic                             res_ok;

  // Shared remainder unit state
  logic [CB-1:0]                    snap_val;
  logic [owt_pkg::SNAP_BITS-1:0]    rem;
  logic [owt_pkg::SNAP_CNT_BITS-1:0] snap_cnt;

  // Combinational helpers
  logic                             accept;
  logic                             snap_on;
  logic                             snap_step;
  logic                             snap_done;
  logic                             next_ok;
  logic                             out_free;
  logic [owt_pkg::SNAP_BITS:0]      rem_shift;
  logic [owt_pkg::SNAP_BITS-1:0]    rem_new;
  logic [CB-1:0]                    snapped;
  logic [CB-1:0]                    span_w, span_h;
  logic [CB:0]                      reach_r, reach_b;
  logic [CB-1:0]                    bright, bbottom;
  logic [CB-1:0]                    bcols_raw, brows_raw;
  logic [CB-1:0]                    sel_w, sel_h, sel_col, sel_row;
  logic                             sel_active;

  assign accept   = s_tvalid && s_tready;
  assign snap_on  = snap_factor > owt_pkg::SNAP_BITS'(1);
  assign out_free = !m_tvalid || m_tready;

  // Band state read at the captured band
  assign sel_active = band_active[band];
  assign sel_w      = band_width[band];
  assign sel_h      = band_height[band];
  assign sel_col    = cursor_column[band];
  assign sel_row    = cursor_row[band];

  assign next_ok = (opcode == owt_pkg::OP_NEXT) && sel_active
                   && (sel_w != '0) && (sel_h != '0)
                   && !((sel_col == sel_w) && (sel_row == sel_h));

  // Tile size before snapping: the maximum tile clipped to the raster edge.
  assign span_w = (max_tile_width  < (sel_w - sel_col)) ? max_tile_width  : (sel_w - sel_col);
  assign span_h = (max_tile_height < (sel_h - sel_row)) ? max_tile_height : (sel_h - sel_row);

  // Far block edges grown by the overlap and clamped to the raster.
  assign reach_r   = {1'b0, tright}  + (CB + 1)'(overlap_pixels);
  assign reach_b   = {1'b0, tbottom} + (CB + 1)'(overlap_pixels);
  assign bright    = (reach_r < {1'b0, cur_w}) ? reach_r[CB-1:0] : cur_w;
  assign bbottom   = (reach_b < {1'b0, cur_h}) ? reach_b[CB-1:0] : cur_h;
  assign bcols_raw = bright - bleft;
  assign brows_raw = bbottom - btop;

  // Shared remainder unit: one dividend bit per cycle, most significant first.
  assign rem_shift = {rem, snap_val[owt_pkg::SNAP_CNT_BITS'(CB - 1) - snap_cnt]};
  assign rem_new   = (rem_shift >= {1'b0, snap_factor})
                     ? owt_pkg::SNAP_BITS'(rem_shift - {1'b0, snap_factor})
                     : rem_shift[owt_pkg::SNAP_BITS-1:0];
  assign snap_done = (snap_cnt == owt_pkg::SNAP_CNT_BITS'(CB - 1));
  assign snapped   = snap_val - CB'(rem_new);

  // Next-state logic
  always_comb begin
    state_next = state;
    unique case (state)
      owt_pkg::S_IDLE:    if (accept) state_next = owt_pkg::S_CHECK;
      owt_pkg::S_CHECK: begin
        if (!next_ok)     state_next = owt_pkg::S_EMIT;
        else if (snap_on) state_next = owt_pkg::S_SNAP_TC;
        else              state_next = owt_pkg::S_EDGE;
      end
      owt_pkg::S_SNAP_TC: if (snap_done) state_next = owt_pkg::S_SNAP_TR;
      owt_pkg::S_SNAP_TR: if (snap_done) state_next = owt_pkg::S_EDGE;
      owt_pkg::S_EDGE:    state_next = owt_pkg::S_BLOCK;
      owt_pkg::S_BLOCK:   state_next = snap_on ? owt_pkg::S_SNAP_BC : owt_pkg::S_FINISH;
      owt_pkg::S_SNAP_BC: if (snap_done) state_next = owt_pkg::S_SNAP_BR;
      owt_pkg::S_SNAP_BR: if (snap_done) state_next = owt_pkg::S_FINISH;
      owt_pkg::S_FINISH:  state_next = owt_pkg::S_EMIT;
      owt_pkg::S_EMIT:    if (out_free) state_next = owt_pkg::S_IDLE;
      default:            state_next = owt_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_tready  = 1'b0;
    snap_step = 1'b0;
    unique case (state)
      owt_pkg::S_IDLE:    s_tready  = 1'b1;
      owt_pkg::S_SNAP_TC,
      owt_pkg::S_SNAP_TR,
      owt_pkg::S_SNAP_BC,
      owt_pkg::S_SNAP_BR: snap_step = 1'b1;
      default: begin
        s_tready  = 1'b0;
        snap_step = 1'b0;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= owt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_tile_width  <= CB'(2000);
      max_tile_height <= CB'(2000);
      overlap_pixels  <= '0;
      snap_factor     <= owt_pkg::SNAP_BITS'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        owt_pkg::REG_MAX_TILE_WIDTH:  max_tile_width  <= cfg_data[CB-1:0];
        owt_pkg::REG_MAX_TILE_HEIGHT: max_tile_height <= cfg_data[CB-1:0];
        owt_pkg::REG_OVERLAP_PIXELS:  overlap_pixels  <= cfg_data[owt_pkg::OVL_BITS-1:0];
        owt_pkg::REG_SNAP_FACTOR:     snap_factor     <= cfg_data[owt_pkg::SNAP_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Band activity flags: set by start, cleared by stop.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < owt_pkg::BANDS; i++) band_active[i] <= 1'b0;
    end else if (state == owt_pkg::S_CHECK) begin
      if (opcode == owt_pkg::OP_START)     band_active[band] <= 1'b1;
      else if (opcode == owt_pkg::OP_STOP) band_active[band] <= 1'b0;
    end
  end

  // Band sizes and cursors
  always_ff @(posedge clk) begin
    if (state == owt_pkg::S_CHECK && opcode == owt_pkg::OP_START) begin
      band_width[band]    <= raster_width;
      band_height[band]   <= raster_height;
      cursor_column[band] <= '0;
      cursor_row[band]    <= '0;
    end else if (state == owt_pkg::S_FINISH && res_ok
                 && !(snap_on && (bcols == '0 || brows == '0))) begin
      if (tright == cur_w && tbottom == cur_h) begin
        cursor_column[band] <= cur_w;
        cursor_row[band]    <= cur_h;
      end else if (tright == cur_w) begin
        cursor_column[band] <= '0;
        cursor_row[band]    <= tbottom;
      end else begin
        cursor_column[band] <= tright;
      end
    end
  end

  // Transaction capture and geometry datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      opcode        <= s_tuser[1:0];
      band          <= s_tuser[3:2];
      raster_width  <= s_tdata[15:0];
      raster_height <= s_tdata[31:16];
    end
    // The last step of a rounding hands over to the state arms below.
    if (snap_step && !snap_done) begin
      rem      <= rem_new;
      snap_cnt <= snap_cnt + owt_pkg::SNAP_CNT_BITS'(1);
    end
    case (state)
      owt_pkg::S_CHECK: begin
        res_ok   <= next_ok;
        cur_w    <= sel_w;
        cur_h    <= sel_h;
        cur_col  <= sel_col;
        cur_row  <= sel_row;
        tcols    <= span_w;
        trows    <= span_h;
        snap_val <= span_w;
        rem      <= '0;
        snap_cnt <= '0;
      end
      owt_pkg::S_SNAP_TC: begin
        if (snap_done) begin
          tcols    <= snapped;
          snap_val <= trows;
          rem      <= '0;
          snap_cnt <= '0;
        end
      end
      owt_pkg::S_SNAP_TR: begin
        if (snap_done) trows <= snapped;
      end
      owt_pkg::S_EDGE: begin
        tright  <= cur_col + tcols;
        tbottom <= cur_row + trows;
        bleft   <= (cur_col >= CB'(overlap_pixels)) ? cur_col - CB'(overlap_pixels) : '0;
        btop    <= (cur_row >= CB'(overlap_pixels)) ? cur_row - CB'(overlap_pixels) : '0;
      end
      owt_pkg::S_BLOCK: begin
        bcols    <= bcols_raw;
        brows    <= brows_raw;
        snap_val <= bcols_raw;
        rem      <= '0;
        snap_cnt <= '0;
      end
      owt_pkg::S_SNAP_BC: begin
        if (snap_done) begin
          bcols    <= snapped;
          snap_val <= brows;
          rem      <= '0;
          snap_cnt <= '0;
        end
      end
      owt_pkg::S_SNAP_BR: begin
        if (snap_done) brows <= snapped;
      end
      owt_pkg::S_FINISH: begin
        // A snapped block with a zero side is refused.
        if (snap_on && (bcols == '0 || brows == '0)) res_ok <= 1'b0;
      end
      default: ;
    endcase
  end

  // Output register: a refused item reports all zeros.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == owt_pkg::S_EMIT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == owt_pkg::S_EMIT && out_free) begin
      m_tuser <= res_ok;
      if (res_ok) begin
        m_tdata <= {cur_row, cur_col, trows, tcols, btop, bleft, brows, bcols};
      end else begin
        m_tdata <= '0;
      end
    end
  end

  // The sequencer takes one transaction at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while an item was still in progress");

  // A refused result carries no geometry.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == '0))
    else $error("refused result carries non-zero fields");

  // The core tile starts inside the overlapped block.
  a_tile_in_block: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[47:32] <= m_tdata[111:96]
                               && m_tdata[63:48] <= m_tdata[127:112]))
    else $error("tile origin lies outside its block");

  // A new result only appears after the emit step.
  a_emit_source: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !$past(m_tvalid)) |-> ($past(state) == owt_pkg::S_EMIT))
    else $error("result raised outside the emit step");

endmodule
